@@ rtl/nv12c_pkg.sv @@
package nv12c_pkg;

    localparam int          MAX_LINE_WIDTH_DEF = 1024;
    localparam int          CFG_W              = 11;
    localparam logic [10:0] LINE_WIDTH_RST     = 11'd800;
    localparam int          ACC_W              = 17;

    localparam logic [ACC_W-1:0] Y_R  = 17'd66;
    localparam logic [ACC_W-1:0] Y_G  = 17'd129;
    localparam logic [ACC_W-1:0] Y_B  = 17'd25;
    localparam logic [ACC_W-1:0] RND  = 17'd128;
    localparam logic [7:0]       Y_OFS = 8'd16;

    localparam logic signed [ACC_W-1:0] U_R = -17'sd38;
    localparam logic signed [ACC_W-1:0] U_G = -17'sd74;
    localparam logic signed [ACC_W-1:0] U_B = 17'sd112;
    localparam logic signed [ACC_W-1:0] V_R = 17'sd112;
    localparam logic signed [ACC_W-1:0] V_G = -17'sd94;
    localparam logic signed [ACC_W-1:0] V_B = -17'sd18;
    localparam logic signed [ACC_W-1:0] C_RND = 17'sd128;
    localparam logic signed [ACC_W-1:0] C_OFS = 17'sd128;
    localparam logic signed [ACC_W-1:0] C_MAX = 17'sd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       start_of_frame;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       chroma_valid;
        logic       line_end;
    } t_pix_out;

endpackage

@@ rtl/rgb_to_nv12_converter.sv @@
// RGB to NV12 (BT.601 studio range, 4:2:0) pixel converter.
// Input channel: i_pix_valid / o_pix_ready carry one raster-order pixel per beat
// on i_pix. The start_of_frame flag restarts the column count and row parity.
// Output channel: o_res_valid / i_res_ready carry one result beat per pixel on
// o_res: luma for every pixel, and U and V with chroma_valid on the odd-row,
// odd-column pixel that completes each 2x2 block. line_end marks a line's end.
// Configuration: i_cfg_we writes i_cfg_data into the line width register; bit 0
// is ignored. Write it only while the block is empty.
// Throughput is one pixel per clock while the receiver does not stall: the
// pipeline has four register stages ending in the output register, and the line
// store has one write and one read port, each used at most once per pixel.
// When the receiver stalls with a result shown, the whole pipeline holds and
// o_pix_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears the pipeline, the column count, the row parity and the held
// pixel, and sets the line width to 800. The line store is not cleared; the
// first odd row of a frame reads only entries the even row above has written.
module rgb_to_nv12_converter #(
    parameter int MAX_LINE_WIDTH = nv12c_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_data,
    input  logic                i_pix_valid,
    output logic                o_pix_ready,
    input  nv12c_pkg::t_pix_in  i_pix,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output nv12c_pkg::t_pix_out o_res
);
    import nv12c_pkg::*;

    localparam int CW       = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int WW       = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int DEPTH    = MAX_LINE_WIDTH / 2;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAX_EVEN = (MAX_LINE_WIDTH / 2) * 2;

    logic [26:0] r_mem [DEPTH];

    logic [10:0]   r_line_width;
    logic [CW-1:0] r_col;
    logic          r_odd;
    logic [23:0]   r_held;

    logic [WW-1:0] w_req;
    logic [WW-1:0] w_clamp;
    logic [CW:0]   w_eff;
    logic [CW-1:0] col_base;
    logic          odd_base;
    logic          wrap;
    logic [CW-1:0] col;
    logic          odd;
    logic          last;
    logic [8:0]    rs, gs, bs;
    logic [AW-1:0] addr;
    logic [ACC_W-1:0] y_sum;
    logic [7:0]    luma;
    logic          en, acc;

    logic        r_v1, r_v2, r_v3, r_v4;
    logic [26:0] r_rd;
    logic [26:0] r_s1_sum;
    logic [7:0]  r_s1_luma, r_s2_luma, r_s3_luma;
    logic        r_s1_cv, r_s2_cv, r_s3_cv;
    logic        r_s1_le, r_s2_le, r_s3_le;
    logic [7:0]  r_ra, r_ga, r_ba;
    logic signed [ACC_W-1:0] r_u, r_v;
    t_pix_out    r_out;

    logic [9:0]  sr, sg, sb;
    logic signed [ACC_W-1:0] s_ra, s_ga, s_ba;
    logic signed [ACC_W-1:0] n_u, n_v;
    logic signed [ACC_W-1:0] u_t, v_t;
    logic [7:0]  u_c, v_c;

    assign en          = !r_v4 || i_res_ready;
    assign o_pix_ready = en;
    assign acc         = i_pix_valid && en;

    always_comb begin
        w_req = WW'({r_line_width[10:1], 1'b0});
        if (w_req > WW'(MAX_EVEN)) begin
            w_clamp = WW'(MAX_EVEN);
        end else if (w_req < WW'(2)) begin
            w_clamp = WW'(2);
        end else begin
            w_clamp = w_req;
        end
        w_eff = (CW + 1)'(w_clamp);

        col_base = i_pix.start_of_frame ? '0 : r_col;
        odd_base = i_pix.start_of_frame ? 1'b0 : r_odd;
        wrap     = ({1'b0, col_base} >= w_eff);
        col      = wrap ? '0 : col_base;
        odd      = odd_base ^ wrap;
        last     = ({1'b0, col} == (w_eff - 1'b1));
        addr     = AW'(col >> 1);

        rs = {1'b0, r_held[23:16]} + {1'b0, i_pix.red};
        gs = {1'b0, r_held[15:8]}  + {1'b0, i_pix.green};
        bs = {1'b0, r_held[7:0]}   + {1'b0, i_pix.blue};

        y_sum = Y_R * ACC_W'(i_pix.red) + Y_G * ACC_W'(i_pix.green)
              + Y_B * ACC_W'(i_pix.blue) + RND;
        luma  = y_sum[15:8] + Y_OFS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_col        <= '0;
            r_odd        <= 1'b0;
            r_held       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_line_width <= i_cfg_data;
            end
            if (acc) begin
                r_col <= last ? '0 : col + 1'b1;
                r_odd <= odd ^ last;
                if (!col[0]) begin
                    r_held <= {i_pix.red, i_pix.green, i_pix.blue};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (col[0] && !odd) begin
                r_mem[addr] <= {rs, gs, bs};
            end
            r_rd <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_pix_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        sr = {1'b0, r_s1_sum[26:18]} + {1'b0, r_rd[26:18]};
        sg = {1'b0, r_s1_sum[17:9]}  + {1'b0, r_rd[17:9]};
        sb = {1'b0, r_s1_sum[8:0]}   + {1'b0, r_rd[8:0]};

        s_ra = $signed(ACC_W'(r_ra));
        s_ga = $signed(ACC_W'(r_ga));
        s_ba = $signed(ACC_W'(r_ba));
        n_u  = U_R * s_ra + U_G * s_ga + U_B * s_ba + C_RND;
        n_v  = V_R * s_ra + V_G * s_ga + V_B * s_ba + C_RND;

        u_t = (r_u >>> 8) + C_OFS;
        v_t = (r_v >>> 8) + C_OFS;
        if (u_t < 0) begin
            u_c = 8'd0;
        end else if (u_t > C_MAX) begin
            u_c = 8'd255;
        end else begin
            u_c = u_t[7:0];
        end
        if (v_t < 0) begin
            v_c = 8'd0;
        end else if (v_t > C_MAX) begin
            v_c = 8'd255;
        end else begin
            v_c = v_t[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sum  <= {rs, gs, bs};
            r_s1_luma <= luma;
            r_s1_cv   <= col[0] && odd;
            r_s1_le   <= last;

            r_ra      <= sr[9:2];
            r_ga      <= sg[9:2];
            r_ba      <= sb[9:2];
            r_s2_luma <= r_s1_luma;
            r_s2_cv   <= r_s1_cv;
            r_s2_le   <= r_s1_le;

            r_u       <= n_u;
            r_v       <= n_v;
            r_s3_luma <= r_s2_luma;
            r_s3_cv   <= r_s2_cv;
            r_s3_le   <= r_s2_le;

            r_out.luma         <= r_s3_luma;
            r_out.chroma_u     <= r_s3_cv ? u_c : 8'd0;
            r_out.chroma_v     <= r_s3_cv ? v_c : 8'd0;
            r_out.chroma_valid <= r_s3_cv;
            r_out.line_end     <= r_s3_le;
        end
    end

    assign o_res_valid = r_v4;
    assign o_res       = r_out;

endmodule

@@ sim/rgb_to_nv12_converter_test.sv @@
`timescale 1ns / 100ps

module rgb_to_nv12_converter_test;

    import nv12c_pkg::*;

    localparam int MAX_W      = MAX_LINE_WIDTH_DEF;
    localparam int PAIR_DEPTH = MAX_W / 2;
    localparam int LIMIT      = 250000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [10:0] i_cfg_data  = '0;
    logic        i_pix_valid = 1'b0;
    logic        o_pix_ready;
    t_pix_in     i_pix       = '0;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    t_pix_out    o_res;

    rgb_to_nv12_converter #(
        .MAX_LINE_WIDTH(MAX_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix_valid(i_pix_valid),
        .o_pix_ready(o_pix_ready),
        .i_pix      (i_pix),
        .o_res_valid(o_res_valid),
        .i_res_ready(i_res_ready),
        .o_res      (o_res)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the converter state.
    logic [26:0] pair_sums    [PAIR_DEPTH];
    bit          pair_written [PAIR_DEPTH];
    logic [23:0] held_rgb  = '0;
    int          col_cnt   = 0;
    bit          row_odd   = 1'b0;
    logic [10:0] width_reg = LINE_WIDTH_RST;

    t_pix_in  pixel_queue  [$];
    t_pix_out expected_res [$];

    int  mismatches     = 0;
    int  beats_checked  = 0;
    int  chroma_checked = 0;
    int  widths_used    = 1;
    int  cycle_count    = 0;
    bit  pix_taken      = 1'b0;
    int  burst_left     = 0;
    int  gap_left       = 0;
    int  ready_left     = 0;

    function automatic int eff_width();
        int w;
        w = int'(width_reg) & ~1;
        if (w > MAX_W) w = MAX_W & ~1;
        if (w < 2) w = 2;
        return w;
    endfunction

    function automatic logic [7:0] clamp_byte(int x);
        if (x < 0) return 8'd0;
        if (x > 255) return 8'd255;
        return x[7:0];
    endfunction

    function automatic bit reads_blank_entry(t_pix_in px);
        int c;
        bit od;
        c  = px.start_of_frame ? 0 : col_cnt;
        od = px.start_of_frame ? 1'b0 : row_odd;
        if (c >= eff_width()) begin
            c  = 0;
            od = !od;
        end
        return od && (c % 2 == 1) && !pair_written[(c / 2) % PAIR_DEPTH];
    endfunction

    function automatic t_pix_out convert_pixel(t_pix_in px);
        t_pix_out res;
        int w, idx, rs, gs, bs, ra, ga, ba, uu, vv;
        res = '0;
        w = eff_width();
        if (px.start_of_frame) begin
            col_cnt = 0;
            row_odd = 1'b0;
        end
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_odd = !row_odd;
        end
        res.luma = 8'((66 * int'(px.red) + 129 * int'(px.green) + 25 * int'(px.blue) + 128)
                      / 256 + 16);
        if (col_cnt % 2 == 0) begin
            held_rgb = {px.red, px.green, px.blue};
        end else begin
            idx = (col_cnt / 2) % PAIR_DEPTH;
            rs  = int'(held_rgb[23:16]) + int'(px.red);
            gs  = int'(held_rgb[15:8]) + int'(px.green);
            bs  = int'(held_rgb[7:0]) + int'(px.blue);
            if (!row_odd) begin
                pair_sums[idx]    = {rs[8:0], gs[8:0], bs[8:0]};
                pair_written[idx] = 1'b1;
            end else begin
                ra = (rs + int'(pair_sums[idx][26:18])) >> 2;
                ga = (gs + int'(pair_sums[idx][17:9])) >> 2;
                ba = (bs + int'(pair_sums[idx][8:0])) >> 2;
                uu = ((-38 * ra - 74 * ga + 112 * ba + 128) >>> 8) + 128;
                vv = ((112 * ra - 94 * ga - 18 * ba + 128) >>> 8) + 128;
                res.chroma_u     = clamp_byte(uu);
                res.chroma_v     = clamp_byte(vv);
                res.chroma_valid = 1'b1;
            end
        end
        res.line_end = (col_cnt == w - 1);
        if (res.line_end) begin
            col_cnt = 0;
            row_odd = !row_odd;
        end else begin
            col_cnt++;
        end
        return res;
    endfunction

    // A pixel that would read a line store entry not yet written restarts the frame.
    task automatic queue_pixel(t_pix_in px);
        if (reads_blank_entry(px)) px.start_of_frame = 1'b1;
        expected_res.push_back(convert_pixel(px));
        pixel_queue.push_back(px);
    endtask

    task automatic queue_block(logic [23:0] p0, logic [23:0] p1, logic [23:0] p2,
                               logic [23:0] p3, logic [3:0] sof_bits);
        logic [23:0] quad [4];
        quad = '{p0, p1, p2, p3};
        for (int k = 0; k < 4; k++) queue_pixel({quad[k], sof_bits[k]});
    endtask

    function automatic t_pix_in random_pixel();
        t_pix_in px;
        bit      corners;
        corners = ($urandom_range(0, 7) == 0);
        px.red   = corners ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom_range(0, 255));
        px.green = corners ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom_range(0, 255));
        px.blue  = corners ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom_range(0, 255));
        px.start_of_frame = 1'b0;
        return px;
    endfunction

    task automatic run_phase(int n, bit sof_first, int noise);
        t_pix_in px;
        for (int i = 0; i < n; i++) begin
            px = random_pixel();
            px.start_of_frame = (i == 0 && sof_first) ||
                                (noise > 0 && $urandom_range(1, noise) == 1);
            queue_pixel(px);
        end
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() != 0 || i_pix_valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_line_width(logic [10:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        width_reg = val;
        widths_used++;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pix_valid <= 1'b0;
        end else if (!i_pix_valid || pix_taken) begin
            if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                i_pix_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                i_pix       <= pixel_queue.pop_front();
                i_pix_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_pix_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if ($urandom_range(0, 2) != 0) begin
            i_res_ready <= 1'b1;
            ready_left  <= $urandom_range(1, 40);
        end else begin
            i_res_ready <= 1'b0;
            ready_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                       : $urandom_range(0, 5);
        end
    end

    always @(posedge i_clk) begin
        t_pix_out want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Timeout after %0d cycles with %0d beats outstanding",
                     cycle_count, expected_res.size());
            $display("Mismatches found");
            $finish;
        end
        pix_taken <= i_rst_n && i_pix_valid && o_pix_ready;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_res.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("Unexpected result beat: Y=%0d U=%0d V=%0d cv=%0b le=%0b",
                             o_res.luma, o_res.chroma_u, o_res.chroma_v,
                             o_res.chroma_valid, o_res.line_end);
            end else begin
                want = expected_res.pop_front();
                beats_checked  <= beats_checked + 1;
                chroma_checked <= chroma_checked + want.chroma_valid;
                if (o_res.luma !== want.luma || o_res.chroma_u !== want.chroma_u ||
                    o_res.chroma_v !== want.chroma_v ||
                    o_res.chroma_valid !== want.chroma_valid ||
                    o_res.line_end !== want.line_end) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"Beat %0d: expected Y=%0d U=%0d V=%0d cv=%0b le=%0b, ",
                                  "got Y=%0d U=%0d V=%0d cv=%0b le=%0b"},
                                 beats_checked, want.luma, want.chroma_u, want.chroma_v,
                                 want.chroma_valid, want.line_end, o_res.luma,
                                 o_res.chroma_u, o_res.chroma_v, o_res.chroma_valid,
                                 o_res.line_end);
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(10, 1'b1, 0);

        set_line_width(11'd0);
        queue_block(24'h000000, 24'h000000, 24'h000000, 24'h000000, 4'b0001);
        queue_block(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'b0000);
        queue_block(24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000, 4'b0000);
        queue_block(24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00, 4'b0000);
        queue_block(24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF, 4'b0000);
        queue_block(24'hFF00FF, 24'h00FF00, 24'h0000FF, 24'hFFFF00, 4'b0100);

        set_line_width(11'd1);
        run_phase(8, 1'b0, 0);
        set_line_width(11'd3);
        run_phase(12, 1'b0, 6);
        set_line_width(11'd16);
        run_phase(20, 1'b1, 10);

        // The second width is below the column reached, so the line in progress wraps on its next pixel.
        set_line_width(11'd37);
        run_phase(48, 1'b1, 0);
        set_line_width(11'd10);
        run_phase(12, 1'b0, 0);

        set_line_width(11'd2047);
        run_phase(MAX_W + 4, 1'b1, 0);
        set_line_width(11'd1025);
        run_phase(12, 1'b0, 0);

        set_line_width(11'd4);
        run_phase(8, 1'b0, 4);

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d result beats, %0d of them with chroma, over %0d width settings.",
                 beats_checked, chroma_checked, widths_used);
        $display("Widths ranged from below the minimum to above the maximum line length.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
